### design/flow_shop_makespan_bound_assert.svh
// ----------------------------------------------------------------------------
// Flow shop makespan bound: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef FLOW_SHOP_MAKESPAN_BOUND_ASSERT_SVH
`define FLOW_SHOP_MAKESPAN_BOUND_ASSERT_SVH

// Plain property, sampled on the rising edge and disabled during reset.
`define FSMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define FSMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fsmb_pkg.sv
// ----------------------------------------------------------------------------
// Flow shop makespan bound: package
// Payload structs, cell control types, opcodes and the saturating adder.
// ----------------------------------------------------------------------------
package fsmb_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned ProcW = 16;
  localparam int unsigned CfgW  = 6;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SCHED  = 2'd1,
    OP_REMAIN = 2'd2,
    OP_BOUND  = 2'd3
  } opcode_e;

  localparam logic KIND_MAKESPAN = 1'b0;
  localparam logic KIND_BOUND    = 1'b1;

  typedef struct packed {
    opcode_e            opcode;
    logic [ProcW-1:0]   proc_time;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [TimeW-1:0]   time_value;
  } out_t;

  // Broadcast to every cell; each cell also gets its own select bit.
  typedef struct packed {
    logic clr;
    logic sched;
    logic remain;
  } cell_ctrl_t;

  // Running maximum that travels down the row during a bound query.
  typedef struct packed {
    logic               vld;
    logic [TimeW-1:0]   max;
  } wave_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

### design/fsmb_cell.sv
// ----------------------------------------------------------------------------
// Flow shop makespan bound: machine cell
// Holds one machine's completion time and remaining-work estimate, applies
// the flow shop recurrence when selected, and forwards the bound wave.
// ----------------------------------------------------------------------------
module fsmb_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fsmb_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         sel_i,
  input  logic                         act_i,
  input  logic [fsmb_pkg::ProcW-1:0]   proc_time_i,
  input  logic [fsmb_pkg::TimeW-1:0]   prev_comp_i,
  output logic [fsmb_pkg::TimeW-1:0]   comp_o,
  output logic [fsmb_pkg::TimeW-1:0]   sched_o,
  input  fsmb_pkg::wave_t              wave_i,
  output fsmb_pkg::wave_t              wave_o
);
  import fsmb_pkg::*;

  logic [TimeW-1:0] comp_q, comp_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic [TimeW-1:0] proc_ext;
  logic [TimeW-1:0] base;
  logic [TimeW-1:0] own_sum;
  wave_t            wave_q, wave_d;

  assign proc_ext = TimeW'(proc_time_i);
  assign base     = (prev_comp_i > comp_q) ? prev_comp_i : comp_q;
  assign sched_o  = sat_add(base, proc_ext);
  assign comp_o   = comp_q;
  assign own_sum  = sat_add(comp_q, rem_q);

  always_comb begin
    comp_d = comp_q;
    rem_d  = rem_q;
    if (ctrl_i.clr) begin
      comp_d = '0;
      rem_d  = '0;
    end else if (sel_i && ctrl_i.sched) begin
      comp_d = sched_o;
    end else if (sel_i && ctrl_i.remain) begin
      rem_d = sat_add(rem_q, proc_ext);
    end
  end

  // Pass the wave on only inside the machines in use.
  always_comb begin
    wave_d.vld = wave_i.vld && act_i;
    wave_d.max = (own_sum > wave_i.max) ? own_sum : wave_i.max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= '0;
      rem_q  <= '0;
      wave_q <= '0;
    end else begin
      comp_q <= comp_d;
      rem_q  <= rem_d;
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

### design/flow_shop_makespan_bound.sv
// ----------------------------------------------------------------------------
// Flow shop makespan bound: top level
// Row of machine cells evaluating a permutation flow shop schedule.
// ----------------------------------------------------------------------------
//  port group    dir  handshake              payload
//  in            in   in_valid_i/in_ready_o  in_data_i  (opcode, proc_time)
//  out           out  out_valid_o/out_ready_i out_data_o (result_kind, time_value)
//  cfg           in   cfg_we_i               cfg_wdata_i (machines_used)
//
//  Clear, schedule and remaining items are applied at their transfer edge; a
//  makespan is loaded into the output register at the transfer edge itself.
//  A bound query walks the cell row, one cell per cycle, and the answer is
//  taken as it leaves machine machines_used (clamped to 1..MAX_MACHINES).
//  Input is held off while a query is in flight or the output slot is full.
//  Reset clears all cells, the position and sets machines_used to 32.
// ----------------------------------------------------------------------------
`include "flow_shop_makespan_bound_assert.svh"

module flow_shop_makespan_bound #(
  parameter int unsigned MAX_MACHINES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fsmb_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fsmb_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fsmb_pkg::CfgW-1:0]     cfg_wdata_i
);
  import fsmb_pkg::*;

  localparam int unsigned PW   = $clog2(MAX_MACHINES);
  localparam int unsigned NW   = $clog2(MAX_MACHINES + 1);
  localparam int unsigned CMPW = (NW > CfgW) ? NW : CfgW;

  logic [CfgW-1:0]  mu_q;
  logic [PW-1:0]    pos_q, pos_d;
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic [CMPW-1:0]  mu_ext;
  logic [CMPW-1:0]  n_ext;
  logic [NW-1:0]    n;
  logic [PW-1:0]    m;
  logic             last;
  logic             in_acc;
  logic             fin;
  cell_ctrl_t       ctrl;

  logic [MAX_MACHINES-1:0] sel;
  logic [MAX_MACHINES-1:0] act;
  logic [MAX_MACHINES-1:0] wave_vld;
  logic [TimeW-1:0]        comp   [MAX_MACHINES];
  logic [TimeW-1:0]        sched  [MAX_MACHINES];
  wave_t                   wave   [MAX_MACHINES+1];

  // Effective machine count, clamped to 1..MAX_MACHINES.
  assign mu_ext = CMPW'(mu_q);
  always_comb begin
    if (mu_q == '0) begin
      n_ext = CMPW'(1);
    end else if (mu_ext > CMPW'(MAX_MACHINES)) begin
      n_ext = CMPW'(MAX_MACHINES);
    end else begin
      n_ext = mu_ext;
    end
  end
  assign n = n_ext[NW-1:0];

  // Treat a stale position as machine zero.
  assign m    = (NW'(pos_q) >= n) ? '0 : pos_q;
  assign last = ((NW'(m) + NW'(1)) == n);

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign ctrl.clr    = in_acc && (in_data_i.opcode == OP_CLEAR);
  assign ctrl.sched  = in_acc && (in_data_i.opcode == OP_SCHED);
  assign ctrl.remain = in_acc && (in_data_i.opcode == OP_REMAIN);

  assign wave[0].vld = in_acc && (in_data_i.opcode == OP_BOUND);
  assign wave[0].max = '0;

  for (genvar i = 0; i < MAX_MACHINES; i++) begin : g_cell
    assign sel[i]      = (m == PW'(i));
    assign act[i]      = (NW'(i) < n);
    assign wave_vld[i] = wave[i+1].vld;

    fsmb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sel_i       (sel[i]),
      .act_i       (act[i]),
      .proc_time_i (in_data_i.proc_time),
      .prev_comp_i ((i == 0) ? '0 : comp[(i == 0) ? 0 : i-1]),
      .comp_o      (comp[i]),
      .sched_o     (sched[i]),
      .wave_i      (wave[i]),
      .wave_o      (wave[i+1])
    );
  end

  assign fin = wave[n].vld;

  always_comb begin
    pos_d       = pos_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.clr) begin
      pos_d = '0;
    end else if (ctrl.sched || ctrl.remain) begin
      pos_d = last ? '0 : (m + PW'(1));
    end
    if (ctrl.sched && last) begin
      out_valid_d       = 1'b1;
      out_d.result_kind = KIND_MAKESPAN;
      out_d.time_value  = sched[m];
    end
    if (wave[0].vld) begin
      busy_d = 1'b1;
    end
    // Collect the query answer as the wave leaves the last machine in use.
    if (fin) begin
      busy_d            = 1'b0;
      out_valid_d       = 1'b1;
      out_d.result_kind = KIND_BOUND;
      out_d.time_value  = wave[n].max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q        <= CfgW'(32);
      pos_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mu_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FSMB_ASSERT_IMP(a_busy_blocks_input, busy_q, !in_ready_o, "input taken during bound query")
  `FSMB_ASSERT(a_single_wave, $onehot0(wave_vld), "more than one bound wave in flight")
  `FSMB_ASSERT_IMP(a_fin_only_busy, fin, busy_q, "bound answer without a pending query")
  `FSMB_ASSERT_NXT(a_query_sets_busy, wave[0].vld, busy_q || out_valid_q, "query not tracked")
  `FSMB_ASSERT_NXT(a_makespan_out, ctrl.sched && last, out_valid_q && (out_q.result_kind == KIND_MAKESPAN), "makespan not registered")

endmodule

### tb/flow_shop_makespan_bound_test.sv
// ----------------------------------------------------------------------------
// Flow shop makespan bound: self-checking testbench
// Drives opcode items through the valid/ready input, compares every makespan
// and bound answer against an in-bench schedule predictor or a pinned value,
// and walks the machine count through its extremes.
// ----------------------------------------------------------------------------
module flow_shop_makespan_bound_test;
  import fsmb_pkg::*;

  localparam int unsigned MachineSlots = 32;
  localparam int unsigned QuietLimit   = 2000;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    in_t         item;
    bit          pinned;
    out_t        pinned_result;
    logic [5:0]  machines;
  } plan_row_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_ready_o;
  in_t             in_data_i    = '0;
  logic            out_valid_o;
  logic            out_ready_i  = 1'b1;
  out_t            out_data_o;
  logic            cfg_we_i     = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i  = '0;

  // Directed-row expectation, travels alongside the input payload.
  bit              in_pinned        = 1'b0;
  out_t            in_pinned_result = '0;

  // Schedule predictor state.
  logic [TimeW-1:0] finish_time [MachineSlots] = '{default: '0};
  logic [TimeW-1:0] backlog     [MachineSlots] = '{default: '0};
  logic [4:0]       slot          = '0;
  logic [CfgW-1:0]  machine_count = 6'd32;

  out_t        awaited_results [$];
  plan_row_t   test_plan [$];

  int unsigned mismatches     = 0;
  int unsigned jobs_in        = 0;
  int unsigned makespans_seen = 0;
  int unsigned bounds_seen    = 0;
  int unsigned writes_seen    = 0;
  int unsigned items_offered  = 0;
  int unsigned quiet_cycles   = 0;
  bit          calm           = 1'b0;

  flow_shop_makespan_bound dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [TimeW-1:0] clamp_add(input logic [TimeW-1:0] a,
                                                 input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = (TimeW+1)'(a) + (TimeW+1)'(b);
    if (s > (TimeW+1)'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return s[TimeW-1:0];
  endfunction

  function automatic int unsigned machines_in_use(input logic [CfgW-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MachineSlots) return MachineSlots;
    return 32'(raw);
  endfunction

  // Apply one item to the schedule state; report the answer it produces.
  task automatic advance_schedule(input in_t it, output bit emits, output out_t res);
    int unsigned n;
    int unsigned m;
    int          k;
    logic [TimeW-1:0] base;
    logic [TimeW-1:0] best;
    logic [TimeW-1:0] sum;
    emits = 1'b0;
    res   = '0;
    n     = machines_in_use(machine_count);
    m     = 32'(slot);
    case (it.opcode)
      OP_CLEAR: begin
        for (k = 0; k < MachineSlots; k++) begin
          finish_time[k] = '0;
          backlog[k]     = '0;
        end
        slot = '0;
      end
      OP_BOUND: begin
        best = '0;
        for (k = 0; k < n; k++) begin
          sum = clamp_add(finish_time[k], backlog[k]);
          if (sum > best) best = sum;
        end
        emits           = 1'b1;
        res.result_kind = KIND_BOUND;
        res.time_value  = best;
      end
      default: begin
        // Stale position after a register write restarts the row.
        if (m >= n) m = 0;
        if (it.opcode == OP_SCHED) begin
          base = (m == 0) ? '0 : finish_time[m-1];
          if (finish_time[m] > base) base = finish_time[m];
          finish_time[m] = clamp_add(base, TimeW'(it.proc_time));
          if (m + 1 == n) begin
            emits           = 1'b1;
            res.result_kind = KIND_MAKESPAN;
            res.time_value  = finish_time[m];
          end
        end else begin
          backlog[m] = clamp_add(backlog[m], TimeW'(it.proc_time));
        end
        slot = (m + 1 == n) ? 5'd0 : 5'(m + 1);
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input logic [TimeW-1:0] seen,
                               input logic [TimeW-1:0] wanted);
    mismatches++;
    $display("mismatch: %s: got 0x%08h, want 0x%08h", what, seen, wanted);
  endtask

  always @(posedge clk_i) begin
    out_t want;
    out_t guess;
    bit   emits;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", out_data_o.time_value, '0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.result_kind != want.result_kind)
            note_mismatch("result_kind", 32'(out_data_o.result_kind),
                          32'(want.result_kind));
          if (out_data_o.time_value != want.time_value)
            note_mismatch("time_value", out_data_o.time_value, want.time_value);
          if (want.result_kind == KIND_BOUND) bounds_seen++;
          else makespans_seen++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        jobs_in++;
        advance_schedule(in_data_i, emits, guess);
        if (emits)
          awaited_results.insert(awaited_results.size(),
                                 in_pinned ? in_pinned_result : guess);
      end
      if (cfg_we_i) begin
        machine_count = cfg_wdata_i;
        writes_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", QuietLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic void plan_item(input opcode_e op, input logic [ProcW-1:0] t,
                                    input bit pinned, input logic [TimeW-1:0] value);
    plan_row_t r;
    r.kind                      = ROW_ITEM;
    r.item.opcode               = op;
    r.item.proc_time            = t;
    r.pinned                    = pinned;
    r.pinned_result.result_kind = (op == OP_BOUND) ? KIND_BOUND : KIND_MAKESPAN;
    r.pinned_result.time_value  = value;
    r.machines                  = '0;
    test_plan.insert(test_plan.size(), r);
  endfunction

  function automatic void plan_write(input logic [CfgW-1:0] n);
    plan_row_t r;
    r          = '{kind: ROW_WRITE, item: '0, pinned: 1'b0, pinned_result: '0, machines: n};
    test_plan.insert(test_plan.size(), r);
  endfunction

  function automatic logic [ProcW-1:0] pick_duration();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 8)  return '0;
    if (p < 16) return '1;
    if (p < 56) return ProcW'($urandom_range(0, 255));
    return ProcW'($urandom_range(0, 65535));
  endfunction

  // Hold valid until the transfer; occasionally drop it for a cycle first.
  task automatic send(input opcode_e op, input logic [ProcW-1:0] t,
                      input bit pinned = 1'b0, input out_t pinned_res = '0);
    items_offered++;
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i                <= 1'b1;
    in_data_i.opcode          <= op;
    in_data_i.proc_time       <= t;
    in_pinned                 <= pinned;
    in_pinned_result          <= pinned_res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drain outstanding answers, then give in-flight silent items time to retire.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_machines(input logic [CfgW-1:0] n);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [CfgW-1:0] phase_machines [10];
    int unsigned     n_used;
    int unsigned     pick;
    int unsigned     span;
    int unsigned     target;
    int unsigned     k;
    int              p;

    // Zeroed state answers zero; a one-machine row exposes the recurrence.
    plan_item(OP_BOUND,  16'h0000, 1, 32'h0000_0000);
    plan_write(6'd1);
    plan_item(OP_SCHED,  16'hFFFF, 1, 32'h0000_FFFF);
    plan_item(OP_SCHED,  16'hFFFF, 1, 32'h0001_FFFE);
    plan_item(OP_REMAIN, 16'hFFFF, 0, '0);
    plan_item(OP_BOUND,  16'h0000, 1, 32'h0002_FFFD);
    plan_item(OP_CLEAR,  16'hFFFF, 0, '0);
    plan_item(OP_BOUND,  16'hFFFF, 1, 32'h0000_0000);
    plan_write(6'd3);
    plan_item(OP_SCHED,  16'd5,    0, '0);
    plan_item(OP_SCHED,  16'd7,    0, '0);
    plan_item(OP_SCHED,  16'd2,    1, 32'd14);
    // Remaining and schedule items share the machine position.
    plan_item(OP_REMAIN, 16'd1,    0, '0);
    plan_item(OP_SCHED,  16'd3,    0, '0);
    plan_item(OP_SCHED,  16'd4,    0, '0);
    plan_item(OP_BOUND,  16'h5A5A, 0, '0);
    // Park the position at machine 1, then shrink the row under it.
    plan_item(OP_SCHED,  16'd0,    0, '0);
    plan_write(6'd2);
    plan_item(OP_SCHED,  16'd1,    0, '0);
    plan_item(OP_SCHED,  16'h8000, 0, '0);
    plan_write(6'd0);
    plan_item(OP_SCHED,  16'h1234, 0, '0);
    plan_item(OP_BOUND,  16'h0000, 0, '0);
    plan_write(6'd63);
    plan_item(OP_BOUND,  16'hA5A5, 0, '0);
    plan_item(OP_CLEAR,  16'h0000, 0, '0);
    plan_item(OP_BOUND,  16'h0000, 1, 32'h0000_0000);

    phase_machines = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd17, 6'd5, 6'd3, 6'd32, 6'd9};
    phase_machines[7] = CfgW'($urandom_range(1, 32));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (test_plan[i]) begin
      if (test_plan[i].kind == ROW_WRITE)
        write_machines(test_plan[i].machines);
      else
        send(test_plan[i].item.opcode, test_plan[i].item.proc_time,
             test_plan[i].pinned, test_plan[i].pinned_result);
    end

    for (p = 0; p < 10; p++) begin
      write_machines(phase_machines[p]);
      n_used = machines_in_use(phase_machines[p]);
      calm   = (p == 4);
      target = items_offered + 160;
      while (items_offered < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          for (k = 0; k < n_used; k++) send(OP_SCHED, pick_duration());
        end else if (pick < 85) begin
          for (k = 0; k < n_used; k++) send(OP_REMAIN, pick_duration());
        end else if (pick < 93) begin
          span = $urandom_range(1, 3);
          for (k = 0; k < span; k++)
            send(opcode_e'($urandom_range(0, 3)), ProcW'($urandom_range(0, 65535)));
        end else if (pick < 96) begin
          send(OP_CLEAR, ProcW'($urandom_range(0, 65535)));
        end else begin
          // Break a row off partway through.
          span = $urandom_range(1, n_used);
          for (k = 0; k < span; k++) send(OP_SCHED, pick_duration());
        end
        if ($urandom_range(0, 99) < 30) send(OP_BOUND, ProcW'($urandom_range(0, 65535)));
      end
    end
    calm = 1'b0;

    settle();
    repeat (40) @(posedge clk_i);

    $display("run: %0d items in, %0d makespans and %0d bounds compared, %0d register writes",
             jobs_in, makespans_seen, bounds_seen, writes_seen);
    $display("run: rows of 1 to 32 machines, clamped counts 0 and 63, stale position, "
             , "broken-off rows and extreme durations");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/fsmb_pkg.sv
design/fsmb_cell.sv
design/flow_shop_makespan_bound.sv
tb/flow_shop_makespan_bound_test.sv
